@@ sv/wes_pkg.sv @@
package wes_pkg;

	// table sizes
	localparam int NUM_NODES      = 64;
	localparam int NODE_W         = 6;
	localparam int MAX_EDGES      = 256;
	localparam int EDGE_W         = 8;
	localparam int EDGE_CNT_W     = 9;
	localparam int MAX_OUT_DEGREE = 8;
	localparam int DEG_W          = 3;
	localparam int LEN_W          = 4;
	localparam int LIST_DEPTH     = NUM_NODES * MAX_OUT_DEGREE;

	// arithmetic widths
	localparam int WEIGHT_BITS = 16;
	localparam int SUM_W       = 19;
	localparam int RND_W       = 17;
	localparam int FRAC_BITS   = 16;
	localparam int TARGET_W    = RND_W + SUM_W;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_SELECT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_TABLE_FULL = 2'd1,
		STATUS_LIST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NODE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                    operation;
		logic [NODE_W-1:0]      source_node;
		logic [NODE_W-1:0]      dest_node;
		logic [WEIGHT_BITS-1:0] edge_weight;
		logic                   binding_allowed;
		logic [RND_W-1:0]       random_fraction;
	} in_item_t;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_index;
		logic              edge_found;
		status_t           status;
	} out_item_t;

	// per-node record: list length and running weight sum
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [SUM_W-1:0] sum;
	} node_rec_t;

	// per-edge record
	typedef struct packed {
		logic [NODE_W-1:0]      dest;
		logic                   bind_flag;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_rec_t;

endpackage

@@ sv/wes_in_if.sv @@
interface wes_in_if;
	logic               valid;
	logic               ready;
	wes_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/wes_out_if.sv @@
interface wes_out_if;
	logic               valid;
	logic               ready;
	wes_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/weighted_edge_selector.sv @@
// channel   dir   payload                                           beats
// cmd       in    operation, nodes, weight, binding flag, random    one per item
// res       out   edge_index, edge_found, status                    one per item
//
// add or a select on an empty or zero-sum list: finished after the node memory read
//   and, for an add, the write-back, with no list walk
// select: walks the list until a hit on list entry n (0..7) or a full miss,
//   through the list memory and edge memory reads streamed one entry a cycle
// one item in work at a time; the result register lets the next beat in while
//   the previous result still waits on res
// reset clears node state through one valid bit per node, no clearing pass
// a stall on res holds the block in its done state until the result register frees
module weighted_edge_selector (
	input  logic      clk,
	input  logic      arst_n,
	wes_in_if.sink    cmd,
	wes_out_if.source res
);

	// control state
	wes_pkg::state_t state_q, state_n;

	// latched command
	wes_pkg::op_t                    op_q;
	logic [wes_pkg::NODE_W-1:0]      src_q;
	logic [wes_pkg::NODE_W-1:0]      dst_q;
	logic [wes_pkg::WEIGHT_BITS-1:0] w_q;
	logic                            bind_q;
	logic [wes_pkg::RND_W-1:0]       rnd_q;

	// node memory: length and weight sum per source, valid bit per node
	wes_pkg::node_rec_t              node_mem [wes_pkg::NUM_NODES];
	wes_pkg::node_rec_t              node_rd_q;
	logic [wes_pkg::NUM_NODES-1:0]   node_vld_q;
	logic                            node_vld_rd_q;
	wes_pkg::node_rec_t              node_cur;

	// outgoing lists, MAX_OUT_DEGREE slots per node
	logic [wes_pkg::EDGE_W-1:0]      list_mem [wes_pkg::LIST_DEPTH];
	logic [wes_pkg::EDGE_W-1:0]      list_rd_q;

	// edge records
	wes_pkg::edge_rec_t              edge_mem [wes_pkg::MAX_EDGES];
	wes_pkg::edge_rec_t              edge_rd_q;

	logic [wes_pkg::EDGE_CNT_W-1:0]  edges_used_q;

	// walk state
	logic [wes_pkg::LEN_W-1:0]       len_q;
	logic [wes_pkg::LEN_W-1:0]       issue_q;
	logic [wes_pkg::LEN_W-1:0]       chk_q;
	logic [wes_pkg::SUM_W-1:0]       accum_q;
	logic [wes_pkg::TARGET_W-1:0]    target_q;
	logic                            v_s1_q;
	logic                            v_s2_q;
	logic [wes_pkg::EDGE_W-1:0]      id_s2_q;

	// pending result and output register
	wes_pkg::out_item_t              pend_q;
	wes_pkg::out_item_t              out_q;
	logic                            out_v_q;

	// combinational control
	logic                            cmd_acc;
	logic                            out_free;
	logic                            add_full;
	logic                            list_full;
	logic                            add_ok;
	logic                            sel_go;
	logic [wes_pkg::SUM_W-1:0]       accum_n;
	logic                            hit;
	logic                            last;
	logic                            walk_end;
	logic                            issue_go;
	logic [wes_pkg::LEN_W-1:0]       issue_idx;
	logic                            load_pend;
	wes_pkg::out_item_t              pend_n;

	// a node never written reads as empty with zero sum
	assign node_cur = node_vld_rd_q ? node_rd_q : '0;

	assign cmd_acc  = cmd.valid & cmd.ready;
	assign out_free = !out_v_q || res.ready;

	assign add_full  = edges_used_q >= wes_pkg::EDGE_CNT_W'(wes_pkg::MAX_EDGES);
	assign list_full = node_cur.len >= wes_pkg::LEN_W'(wes_pkg::MAX_OUT_DEGREE);
	assign add_ok    = (op_q == wes_pkg::OP_ADD) && !add_full && !list_full;
	assign sel_go    = (op_q == wes_pkg::OP_SELECT) && (node_cur.len != '0)
		&& (node_cur.sum != '0);

	// roulette test: cumulative weight scaled to Q.16 against random times sum
	assign accum_n = accum_q + wes_pkg::SUM_W'(edge_rd_q.weight);
	assign hit     = v_s2_q && (wes_pkg::TARGET_W'({accum_n, {wes_pkg::FRAC_BITS{1'b0}}})
		>= target_q);
	assign last    = v_s2_q && (chk_q == len_q - wes_pkg::LEN_W'(1));
	assign walk_end = hit || last;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			wes_pkg::ST_IDLE: begin
				if (cmd_acc) state_n = wes_pkg::ST_NODE;
			end
			wes_pkg::ST_NODE: begin
				state_n = sel_go ? wes_pkg::ST_WALK : wes_pkg::ST_DONE;
			end
			wes_pkg::ST_WALK: begin
				if (walk_end) state_n = wes_pkg::ST_DONE;
			end
			wes_pkg::ST_DONE: begin
				if (out_free) state_n = wes_pkg::ST_IDLE;
			end
			default: state_n = wes_pkg::ST_IDLE;
		endcase
	end

	// outputs and strobes
	always_comb begin
		cmd.ready = 1'b0;
		issue_go  = 1'b0;
		issue_idx = issue_q;
		load_pend = 1'b0;
		pend_n    = '{edge_index: '0, edge_found: 1'b0, status: wes_pkg::STATUS_OK};
		unique case (state_q)
			wes_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			wes_pkg::ST_NODE: begin
				// first list read goes out with the node lookup result
				issue_go  = sel_go;
				issue_idx = '0;
				load_pend = !sel_go;
				priority if (op_q == wes_pkg::OP_ADD && add_full) begin
					pend_n.status = wes_pkg::STATUS_TABLE_FULL;
				end else if (op_q == wes_pkg::OP_ADD && list_full) begin
					pend_n.status = wes_pkg::STATUS_LIST_FULL;
				end else if (op_q == wes_pkg::OP_ADD) begin
					pend_n.edge_index = edges_used_q[wes_pkg::EDGE_W-1:0];
					pend_n.edge_found = 1'b1;
				end else begin
					pend_n.edge_found = 1'b0;
				end
			end
			wes_pkg::ST_WALK: begin
				issue_go  = (issue_q < len_q) && !walk_end;
				load_pend = walk_end;
				if (hit) begin
					pend_n.edge_index = id_s2_q;
					pend_n.edge_found = 1'b1;
				end
			end
			wes_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= wes_pkg::ST_IDLE;
			out_v_q      <= 1'b0;
			edges_used_q <= '0;
			node_vld_q   <= '0;
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == wes_pkg::ST_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == wes_pkg::ST_NODE && add_ok) begin
				edges_used_q       <= edges_used_q + wes_pkg::EDGE_CNT_W'(1);
				node_vld_q[src_q]  <= 1'b1;
			end
			v_s1_q <= issue_go;
			v_s2_q <= v_s1_q && (state_q == wes_pkg::ST_WALK) && !walk_end;
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q          <= cmd.payload.operation;
			src_q         <= cmd.payload.source_node;
			dst_q         <= cmd.payload.dest_node;
			w_q           <= cmd.payload.edge_weight;
			bind_q        <= cmd.payload.binding_allowed;
			rnd_q         <= cmd.payload.random_fraction;
			node_vld_rd_q <= node_vld_q[cmd.payload.source_node];
		end
		if (state_q == wes_pkg::ST_NODE) begin
			len_q    <= node_cur.len;
			issue_q  <= wes_pkg::LEN_W'(1);
			chk_q    <= '0;
			accum_q  <= '0;
			target_q <= wes_pkg::TARGET_W'(rnd_q) * wes_pkg::TARGET_W'(node_cur.sum);
		end else if (state_q == wes_pkg::ST_WALK) begin
			if (issue_go) issue_q <= issue_q + wes_pkg::LEN_W'(1);
			if (v_s2_q) begin
				accum_q <= accum_n;
				chk_q   <= chk_q + wes_pkg::LEN_W'(1);
			end
		end
		if (v_s1_q) id_s2_q <= list_rd_q;
		if (load_pend) pend_q <= pend_n;
		if (state_q == wes_pkg::ST_DONE && out_free) out_q <= pend_q;
	end

	// node memory
	always_ff @(posedge clk) begin
		if (state_q == wes_pkg::ST_NODE && add_ok) begin
			node_mem[src_q] <= '{len: node_cur.len + wes_pkg::LEN_W'(1),
				sum: node_cur.sum + wes_pkg::SUM_W'(w_q)};
		end
		if (cmd_acc) node_rd_q <= node_mem[cmd.payload.source_node];
	end

	// list memory
	always_ff @(posedge clk) begin
		if (state_q == wes_pkg::ST_NODE && add_ok) begin
			list_mem[{src_q, node_cur.len[wes_pkg::DEG_W-1:0]}] <=
				edges_used_q[wes_pkg::EDGE_W-1:0];
		end
		if (issue_go) list_rd_q <= list_mem[{src_q, issue_idx[wes_pkg::DEG_W-1:0]}];
	end

	// edge memory, addressed straight from the list read data
	always_ff @(posedge clk) begin
		if (state_q == wes_pkg::ST_NODE && add_ok) begin
			edge_mem[edges_used_q[wes_pkg::EDGE_W-1:0]] <=
				'{dest: dst_q, bind_flag: bind_q, weight: w_q};
		end
		if (v_s1_q) edge_rd_q <= edge_mem[list_rd_q];
	end

	assign res.valid   = out_v_q;
	assign res.payload = out_q;

`ifndef SYNTH
	// edge count never passes the table size
	a_edges_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edges_used_q <= wes_pkg::EDGE_CNT_W'(wes_pkg::MAX_EDGES))
		else $error("edge count beyond table size");

	// a successful add moves the edge count by exactly one
	a_edges_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wes_pkg::ST_NODE && add_ok)
		|=> edges_used_q == $past(edges_used_q) + wes_pkg::EDGE_CNT_W'(1))
		else $error("edge count step");

	// read stages only carry entries during a walk
	a_walk_stages: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q) |-> state_q == wes_pkg::ST_WALK)
		else $error("walk stage busy outside walk");

	// the walk ends before checking past the list length
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wes_pkg::ST_WALK |-> chk_q < len_q)
		else $error("walk ran past list end");

	// a found result always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.payload.edge_found) |-> res.payload.status == wes_pkg::STATUS_OK)
		else $error("found result with error status");
`endif

endmodule
